// ===== hdl/csm_pkg.sv =====
// shared types and constants for the subarray sum match unit
package csm_pkg;

	localparam int unsigned SUM_W            = 37;
	localparam int unsigned VALUE_W          = 31;
	localparam int unsigned IDX_W            = 6;
	localparam int unsigned MAX_ELEMENTS_DEF = 64;
	localparam int unsigned QUEUE_DEPTH      = 2;
	localparam int unsigned IN_DATA_W        = 32;
	localparam int unsigned OUT_DATA_W       = 16;

	// one classified element on its way from front to back
	typedef struct packed {
		logic             drop;
		logic [IDX_W-1:0] end_idx;
		logic [SUM_W-1:0] prev_total;
		logic [SUM_W-1:0] key;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [IDX_W-1:0] start_index;
		logic [IDX_W-1:0] end_index;
		logic             dropped;
		logic             last_of_run;
	} result_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_FLUSH,
		B_DROP
	} back_state_t;

endpackage

// ===== hdl/contiguous_subarray_sum_match_unit.sv =====
// Reports every contiguous run of a list whose sum equals target_sum. Elements enter on the
// slave stream (tlast closes the list); each accepted element is classified at once and queued,
// and the back end stores its prefix in a single-port prefix memory and reads the stored
// prefixes back one a cycle while no held match waits on a stalled master side. An element
// past MAX_ELEMENTS gives one result with the dropped flag set. The front accepts while the
// two-entry command queue has room, so input transfers keep flowing during a scan. Results
// leave ordered by end index, then start index; tlast marks the last result of an element,
// and an element with no matching run gives no result. The user must write target_sum only
// while idle; the block itself does not enforce it.
module contiguous_subarray_sum_match_unit #(
	parameter int unsigned MAX_ELEMENTS = csm_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [csm_pkg::SUM_W-1:0]     cfg_wr_data,   // target_sum
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [csm_pkg::IN_DATA_W-1:0] s_axis_tdata,  // value[30:0], zero pad
	input  logic                          s_axis_tlast,  // last_in_list
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [csm_pkg::OUT_DATA_W-1:0] m_axis_tdata, // start_index[5:0], end_index[11:6]
	output logic                          m_axis_tuser,  // dropped
	output logic                          m_axis_tlast   // last_of_run
);
	import csm_pkg::*;

	logic    f_valid;
	logic    f_ready;
	cmd_t    f_cmd;
	logic    q_valid;
	logic    q_ready;
	cmd_t    q_cmd;
	result_t res;

	csm_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_value   (s_axis_tdata[VALUE_W-1:0]),
		.in_last    (s_axis_tlast),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready),
		.cmd        (f_cmd)
	);

	csm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (f_cmd),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_data (q_cmd)
	);

	csm_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd      (q_cmd),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = {(OUT_DATA_W - 2 * IDX_W)'(0), res.end_index, res.start_index};
	assign m_axis_tuser = res.dropped;
	assign m_axis_tlast = res.last_of_run;

endmodule

// ===== hdl/csm_front.sv =====
// front end: accepts elements, keeps running total and count, builds commands
module csm_front #(
	parameter int unsigned MAX_ELEMENTS = csm_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [csm_pkg::SUM_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [csm_pkg::VALUE_W-1:0] in_value,
	input  logic                       in_last,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output csm_pkg::cmd_t              cmd
);
	import csm_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

	logic [SUM_W-1:0] target_q;
	logic [SUM_W-1:0] total_q;
	logic [CW-1:0]    count_q;
	logic [SUM_W-1:0] after;
	logic             full;
	logic             take;

	assign full      = (count_q >= CW'(MAX_ELEMENTS));
	assign after     = total_q + SUM_W'(in_value);
	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign take      = in_valid && cmd_ready;

	always_comb begin
		cmd.drop       = full;
		cmd.end_idx    = IDX_W'(count_q);
		cmd.prev_total = total_q;
		// a stored prefix equal to this key closes a matching run
		cmd.key        = after - target_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_wr_en) begin
			target_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
		end else if (take) begin
			if (in_last) begin
				total_q <= '0;
				count_q <= '0;
			end else if (!full) begin
				total_q <= after;
				count_q <= count_q + CW'(1);
			end
		end
	end

endmodule

// ===== hdl/csm_queue.sv =====
// short command queue between front and back
module csm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  csm_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output csm_pkg::cmd_t rd_data
);
	import csm_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          push;
	logic          pop;

	assign wr_ready = (fill_q != NW'(QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

// ===== hdl/csm_back.sv =====
// back end: prefix store, scan over stored prefixes and result register
module csm_back #(
	parameter int unsigned MAX_ELEMENTS = csm_pkg::MAX_ELEMENTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  csm_pkg::cmd_t   cmd,
	output logic            res_valid,
	input  logic            res_ready,
	output csm_pkg::result_t res
);
	import csm_pkg::*;

	localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	logic [SUM_W-1:0] mem [MAX_ELEMENTS];

	back_state_t      state_q, state_d;
	logic [IDX_W-1:0] end_q;
	logic [SUM_W-1:0] key_q;
	logic [IDX_W-1:0] addr_q;
	logic             issue_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [SUM_W-1:0] rd_data_s1;
	logic             pend_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             out_free;
	logic             hit;
	logic             pop;
	logic             advance;
	logic             emit_mid;
	logic             emit_fin;
	logic             emit_drop;
	logic             out_load;

	assign out_free  = !out_valid_q || res_ready;
	assign hit       = (rd_data_s1 == key_q);
	assign out_load  = emit_mid || emit_fin || emit_drop;
	assign cmd_ready = pop;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					state_d = cmd.drop ? B_DROP : B_SCAN;
				end
			end
			B_SCAN: begin
				if (!issue_q && !rd_valid_s1) begin
					state_d = B_FLUSH;
				end
			end
			B_FLUSH: begin
				if (!pend_q || out_free) begin
					state_d = B_IDLE;
				end
			end
			B_DROP: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop       = 1'b0;
		advance   = 1'b0;
		emit_mid  = 1'b0;
		emit_fin  = 1'b0;
		emit_drop = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop = cmd_valid;
			end
			B_SCAN: begin
				// a second match must wait until the held one has left
				advance  = !(rd_valid_s1 && hit && pend_q && !out_free);
				emit_mid = advance && rd_valid_s1 && hit && pend_q;
			end
			B_FLUSH: begin
				emit_fin = pend_q && out_free;
			end
			B_DROP: begin
				emit_drop = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && !cmd.drop) begin
			mem[cmd.end_idx[AW-1:0]] <= cmd.prev_total;
		end
		if (advance && issue_q) begin
			rd_data_s1 <= mem[addr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			end_q <= cmd.end_idx;
			key_q <= cmd.key;
		end
		if (advance && issue_q) begin
			rd_idx_s1 <= addr_q;
		end
		if (advance && rd_valid_s1 && hit) begin
			pend_idx_q <= rd_idx_s1;
		end
		if (out_load) begin
			out_q.start_index <= emit_drop ? '0 : pend_idx_q;
			out_q.end_index   <= emit_drop ? '0 : end_q;
			out_q.dropped     <= emit_drop;
			out_q.last_of_run <= emit_drop || emit_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			addr_q      <= '0;
			issue_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && !cmd.drop) begin
				addr_q  <= '0;
				issue_q <= 1'b1;
			end else if (advance) begin
				rd_valid_s1 <= issue_q;
				if (issue_q) begin
					if (addr_q == end_q) begin
						issue_q <= 1'b0;
					end else begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
			end
			if (advance && rd_valid_s1 && hit) begin
				pend_q <= 1'b1;
			end else if (emit_fin) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_drop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.dropped |-> out_q.last_of_run)
		else $error("dropped result without last_of_run");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten while still held");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (rd_idx_s1 <= end_q) && (state_q == B_SCAN))
		else $error("prefix read outside the current run");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == B_SCAN || state_q == B_FLUSH))
		else $error("held match outside scan");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SCAN) && !issue_q && !rd_valid_s1 |=> state_q == B_FLUSH)
		else $error("scan did not hand over to flush");

endmodule

// ===== sim/testbench.sv =====
// testbench for the contiguous subarray sum match unit
`timescale 1ns / 100ps
module testbench;
	import csm_pkg::*;

	localparam int unsigned MAX_EL = MAX_ELEMENTS_DEF;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned RANDOM_ITEMS = 300;
	localparam int unsigned MAX_PRINTED = 50;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	typedef enum int unsigned {
		VALS_SMALL,
		VALS_WINDOW,
		VALS_NOISE
	} list_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [SUM_W-1:0]      cfg_wr_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // value[30:0], zero pad
	logic                  s_axis_tlast = 1'b0; // last_in_list
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // start_index[5:0], end_index[11:6]
	logic                  m_axis_tuser;        // dropped
	logic                  m_axis_tlast;        // last_of_run

	contiguous_subarray_sum_match_unit #(
		.MAX_ELEMENTS(MAX_EL)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// own copy of the block state
	logic [SUM_W-1:0] match_target = '0;
	logic [SUM_W-1:0] prefix_sums [MAX_EL];
	logic [SUM_W-1:0] list_total = '0;
	int unsigned      list_count = 0;
	result_t          pending_pairs [$];

	int unsigned      mismatch_count = 0;
	int unsigned      cycle_count = 0;
	int unsigned      items_sent = 0;
	int unsigned      burst_left = 0;
	bit               quiet = 1'b0;
	logic [VALUE_W-1:0] list_vals [80];

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	// every (start, end) run summing to the target, end by arrival; a drop once store full
	task automatic predict_pairs(input logic [VALUE_W-1:0] v, input logic last);
		logic [SUM_W-1:0] after;
		logic [SUM_W-1:0] run_sum;
		result_t          held;
		bit               have_held;
		have_held = 1'b0;
		held = '0;
		if (list_count >= MAX_EL) begin
			held.dropped = 1'b1;
			have_held = 1'b1;
		end else begin
			after = list_total + {{(SUM_W-VALUE_W){1'b0}}, v};
			prefix_sums[list_count] = list_total;
			for (int unsigned s = 0; s <= list_count; s++) begin
				run_sum = after - prefix_sums[s];
				if (run_sum == match_target) begin
					if (have_held)
						pending_pairs.push_back(held);
					held = '0;
					held.start_index = s[IDX_W-1:0];
					held.end_index = list_count[IDX_W-1:0];
					have_held = 1'b1;
				end
			end
			list_total = after;
			list_count++;
		end
		if (have_held) begin
			held.last_of_run = 1'b1;
			pending_pairs.push_back(held);
		end
		if (last) begin
			list_total = '0;
			list_count = 0;
		end
	endtask

	// one element on the slave side, with bursts and gaps between them unless quiet
	task automatic send_element(input logic [VALUE_W-1:0] v, input logic last);
		int unsigned gap;
		gap = 0;
		if (!quiet) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, v};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_pairs(v, last);
		items_sent++;
	endtask

	task automatic send_list(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_element(list_vals[i], i == len - 1);
	endtask

	// drop valid, wait for every expected transfer, then let the back end run dry
	task automatic settle_block();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input logic [SUM_W-1:0] t);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= t;
		match_target = t;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver stalls: always ready, coin toss, or a repeating 8-bit mask
	initial begin : rx_stall
		int unsigned rx_mode;
		int unsigned rx_hold;
		logic [7:0]  rx_mask;
		rx_mode = 0;
		rx_hold = 0;
		rx_mask = 8'hff;
		forever begin
			@(negedge clk);
			if (rx_hold == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mask = 8'($urandom_range(1, 255));
				rx_hold = $urandom_range(32, 256);
			end
			rx_hold--;
			if (quiet || rx_mode == 0)
				m_axis_tready <= 1'b1;
			else if (rx_mode == 1)
				m_axis_tready <= 1'($urandom_range(0, 1));
			else
				m_axis_tready <= rx_mask[cycle_count % 8];
		end
	end

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.start_index = m_axis_tdata[5:0];
			got.end_index = m_axis_tdata[11:6];
			got.dropped = m_axis_tuser;
			got.last_of_run = m_axis_tlast;
			if (pending_pairs.size() == 0) begin
				report_mismatch($sformatf("unexpected result start %0d end %0d",
					got.start_index, got.end_index));
			end else begin
				want = pending_pairs.pop_front();
				if (got.start_index != want.start_index)
					report_mismatch($sformatf("start_index %0d, wanted %0d",
						got.start_index, want.start_index));
				if (got.end_index != want.end_index)
					report_mismatch($sformatf("end_index %0d, wanted %0d",
						got.end_index, want.end_index));
				if (got.dropped != want.dropped)
					report_mismatch($sformatf("dropped %0b, wanted %0b",
						got.dropped, want.dropped));
				if (got.last_of_run != want.last_of_run)
					report_mismatch($sformatf("last_of_run %0b, wanted %0b",
						got.last_of_run, want.last_of_run));
			end
		end
	end

	// target left at its reset value of zero: zero elements match on their own
	task automatic test_reset_target();
		list_vals[0] = 0;
		list_vals[1] = 4;
		list_vals[2] = 0;
		send_list(3);
		settle_block();
	endtask

	task automatic test_directed_runs();
		write_target(10);
		list_vals[0] = 3;
		list_vals[1] = 7;
		list_vals[2] = 0;
		list_vals[3] = 10;
		list_vals[4] = 5;
		list_vals[5] = 5;
		send_list(6);
		settle_block();

		write_target({{(SUM_W-VALUE_W){1'b0}}, VALUE_MAX});
		list_vals[0] = VALUE_MAX;
		list_vals[1] = 0;
		list_vals[2] = VALUE_MAX;
		send_list(3);
		settle_block();

		// largest target is out of reach of any list, so no transfer at all
		write_target(SUM_MAX);
		list_vals[0] = VALUE_MAX;
		list_vals[1] = VALUE_MAX;
		send_list(2);
		list_vals[0] = 5;
		send_list(1);
		settle_block();

		write_target(37'h2AAAAAAA + 37'h55555555);
		list_vals[0] = 31'h2AAAAAAA;
		list_vals[1] = 31'h55555555;
		send_list(2);
		settle_block();

		write_target(0);
		list_vals[0] = 0;
		send_list(1);
		list_vals[0] = 7;
		list_vals[1] = 0;
		list_vals[2] = 0;
		send_list(3);
		settle_block();
	endtask

	// fill the store, overflow it, close the list on a dropped element, then start afresh
	task automatic test_store_full();
		write_target(5);
		for (int i = 0; i < MAX_EL + 3; i++)
			list_vals[i] = VALUE_W'($urandom_range(0, 3));
		send_list(MAX_EL + 3);
		list_vals[0] = 5;
		send_list(1);
		for (int i = 0; i < MAX_EL; i++)
			list_vals[i] = VALUE_W'($urandom_range(0, 3));
		send_list(MAX_EL);
		list_vals[0] = 5;
		send_list(1);
		settle_block();
	endtask

	task automatic build_list(input list_kind_t kind, output int unsigned len);
		int unsigned pick;
		logic [31:0] raw;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			len = $urandom_range(1, 16);
		else if (pick < 96)
			len = $urandom_range(17, 40);
		else
			len = $urandom_range(MAX_EL, MAX_EL + 4);
		for (int unsigned i = 0; i < len; i++) begin
			raw = $urandom();
			if (kind == VALS_SMALL)
				list_vals[i] = VALUE_W'($urandom_range(0, 3));
			else
				list_vals[i] = raw[VALUE_W-1:0];
		end
	endtask

	task automatic test_random_lists();
		int unsigned goal;
		int unsigned len;
		int unsigned s_pick;
		int unsigned e_pick;
		list_kind_t  kind;
		logic [SUM_W-1:0] tgt;
		logic [63:0] wide;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			kind = list_kind_t'($urandom_range(0, 2));
			quiet = ($urandom_range(0, 4) == 0);
			build_list(kind, len);
			wide = {$urandom(), $urandom()};
			case (kind)
				VALS_SMALL: begin
					tgt = SUM_W'($urandom_range(0, 10));
				end
				VALS_WINDOW: begin
					// target taken from a window of the list so wide values still match
					s_pick = $urandom_range(0, len - 1);
					e_pick = $urandom_range(s_pick, len - 1);
					if (e_pick >= MAX_EL)
						e_pick = MAX_EL - 1;
					if (s_pick > e_pick)
						s_pick = e_pick;
					tgt = '0;
					for (int unsigned i = s_pick; i <= e_pick; i++)
						tgt = tgt + {{(SUM_W-VALUE_W){1'b0}}, list_vals[i]};
				end
				default: begin
					case ($urandom_range(0, 2))
						0: tgt = '0;
						1: tgt = SUM_MAX;
						default: tgt = wide[SUM_W-1:0];
					endcase
				end
			endcase
			write_target(tgt);
			send_list(len);
			if (kind == VALS_SMALL) begin
				repeat ($urandom_range(0, 3)) begin
					build_list(kind, len);
					send_list(len);
				end
			end
			settle_block();
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_target();
		test_directed_runs();
		test_store_full();
		test_random_lists();
		if (mismatch_count == 0 && pending_pairs.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
